FILE: rtl/ipsv_pkg.sv
// shared constants, types and the sector lookup for the inverse park / svpwm pipeline
// no dependencies

package ipsv_pkg;

    localparam int NUM_STAGES  = 23;
    localparam int TRIG_STAGES = 5;
    localparam int PARK_STAGES = 9;
    localparam int DUTY_STAGES = NUM_STAGES - PARK_STAGES;
    localparam int DIV_BITS    = 11;

    localparam logic [16:0] SQRT3_Q16     = 17'd113512;
    localparam logic [14:0] INV_SQRT3_Q15 = 15'd18919;
    localparam logic [16:0] SIN_CA        = 17'd102944;
    localparam logic [15:0] SIN_CB        = 16'd42048;
    localparam logic [12:0] SIN_CC        = 13'd4640;
    localparam logic [11:0] PWM_FULL      = 12'd2048;
    localparam logic [14:0] SUPPLY_RESET  = 15'd3072;
    localparam logic [14:0] LIM_RESET     = 15'((3072 * 18919 + 16384) >> 15);

    typedef enum logic [2:0] {
        SEC_NONE = 3'd0,
        SEC_1    = 3'd1,
        SEC_2    = 3'd2,
        SEC_3    = 3'd3,
        SEC_4    = 3'd4,
        SEC_5    = 3'd5,
        SEC_6    = 3'd6
    } sector_t;

    typedef logic signed [27:0] lvec_t;

    // sign code n = 4c + 2b + a
    function automatic sector_t sector_lookup(input logic [2:0] n);
        sector_t s;
        unique case (n)
            3'd1:    s = SEC_2;
            3'd2:    s = SEC_6;
            3'd3:    s = SEC_1;
            3'd4:    s = SEC_4;
            3'd5:    s = SEC_3;
            3'd6:    s = SEC_5;
            default: s = SEC_NONE;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/ipsv_trig.sv
// five-stage polynomial sine and cosine in q1.15 from a 20-bit phase
// depends on ipsv_pkg

module ipsv_trig (
    input  logic                               clk,
    input  logic [ipsv_pkg::TRIG_STAGES-1:0]   stage_en,
    input  logic [19:0]                        phase,
    output logic signed [15:0]                 sin_val,
    output logic signed [15:0]                 cos_val
);

    logic [1:0]  quad_c [2];
    logic [18:0] fold_c [2];
    logic [33:0] prod2_c [2];
    logic [29:0] prod3_c [2];
    logic [33:0] prod4_c [2];
    logic [33:0] prod5_c [2];
    logic [18:0] round_c [2];
    logic [14:0] mag_c [2];

    logic [16:0] u1_reg [2];
    logic [16:0] u1_next [2];
    logic        neg1_reg [2];
    logic        neg1_next [2];
    logic [16:0] u2_reg [2];
    logic [16:0] sq2_reg [2];
    logic [16:0] sq2_next [2];
    logic        neg2_reg [2];
    logic [16:0] u3_reg [2];
    logic [16:0] sq3_reg [2];
    logic [15:0] inner3_reg [2];
    logic [15:0] inner3_next [2];
    logic        neg3_reg [2];
    logic [16:0] u4_reg [2];
    logic [16:0] mid4_reg [2];
    logic [16:0] mid4_next [2];
    logic        neg4_reg [2];
    logic signed [15:0] val5_reg [2];
    logic signed [15:0] val5_next [2];

    // lane 0 sine, lane 1 cosine (quarter turn ahead)
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            quad_c[i]   = phase[19:18] + 2'(i);
            fold_c[i]   = quad_c[i][0] ? (19'h40000 - {1'b0, phase[17:0]})
                                       : {1'b0, phase[17:0]};
            u1_next[i]  = fold_c[i][18:2];
            neg1_next[i] = quad_c[i][1];

            prod2_c[i]  = 34'(u1_reg[i]) * 34'(u1_reg[i]);
            sq2_next[i] = prod2_c[i][32:16];

            prod3_c[i]    = 30'(sq2_reg[i]) * 30'(ipsv_pkg::SIN_CC);
            inner3_next[i] = ipsv_pkg::SIN_CB - {2'b00, prod3_c[i][29:16]};

            prod4_c[i]   = 34'(sq3_reg[i]) * 34'(inner3_reg[i]);
            mid4_next[i] = ipsv_pkg::SIN_CA - prod4_c[i][32:16];

            prod5_c[i]  = 34'(u4_reg[i]) * 34'(mid4_reg[i]);
            round_c[i]  = {1'b0, prod5_c[i][33:16]} + 19'd1;
            mag_c[i]    = (round_c[i][18:1] > 18'd32767) ? 15'h7fff : round_c[i][15:1];
            val5_next[i] = neg4_reg[i] ? -$signed({1'b0, mag_c[i]})
                                       : $signed({1'b0, mag_c[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (stage_en[0])
            begin
                u1_reg[i]   <= u1_next[i];
                neg1_reg[i] <= neg1_next[i];
            end
            if (stage_en[1])
            begin
                u2_reg[i]   <= u1_reg[i];
                sq2_reg[i]  <= sq2_next[i];
                neg2_reg[i] <= neg1_reg[i];
            end
            if (stage_en[2])
            begin
                u3_reg[i]     <= u2_reg[i];
                sq3_reg[i]    <= sq2_reg[i];
                inner3_reg[i] <= inner3_next[i];
                neg3_reg[i]   <= neg2_reg[i];
            end
            if (stage_en[3])
            begin
                u4_reg[i]   <= u3_reg[i];
                mid4_reg[i] <= mid4_next[i];
                neg4_reg[i] <= neg3_reg[i];
            end
            if (stage_en[4])
            begin
                val5_reg[i] <= val5_next[i];
            end
        end
    end

    assign sin_val = val5_reg[0];
    assign cos_val = val5_reg[1];

endmodule

FILE: rtl/ipsv_park.sv
// command clamp, inverse park rotation, sector decode and per-phase duty terms
// depends on ipsv_pkg; takes sine and cosine from ipsv_trig

module ipsv_park (
    input  logic                               clk,
    input  logic [ipsv_pkg::PARK_STAGES-1:0]   stage_en,
    input  logic signed [15:0]                 q_cmd,
    input  logic signed [15:0]                 d_cmd,
    input  logic [14:0]                        limit,
    input  logic signed [15:0]                 sin_val,
    input  logic signed [15:0]                 cos_val,
    output ipsv_pkg::sector_t                  sector,
    output ipsv_pkg::lvec_t                    l_a,
    output ipsv_pkg::lvec_t                    l_b,
    output ipsv_pkg::lvec_t                    l_c
);

    logic signed [15:0] lim_s;
    logic signed [15:0] uq_next;
    logic signed [15:0] ud_next;
    logic signed [15:0] uq_reg [ipsv_pkg::TRIG_STAGES];
    logic signed [15:0] ud_reg [ipsv_pkg::TRIG_STAGES];

    logic signed [31:0] p_reg [4];
    logic signed [31:0] p_next [4];
    logic signed [32:0] diff_c;
    logic signed [32:0] sum_c;
    logic signed [25:0] al_reg;
    logic signed [25:0] be7_reg;
    logic signed [43:0] sa_prod_c;
    logic signed [27:0] sa_reg;
    logic signed [25:0] be8_reg;

    logic signed [27:0] a_c;
    logic signed [27:0] b_c;
    logic signed [27:0] c_c;
    ipsv_pkg::sector_t  sec_next;
    ipsv_pkg::sector_t  sec_reg;
    ipsv_pkg::lvec_t    la_next;
    ipsv_pkg::lvec_t    lb_next;
    ipsv_pkg::lvec_t    lc_next;
    ipsv_pkg::lvec_t    la_reg;
    ipsv_pkg::lvec_t    lb_reg;
    ipsv_pkg::lvec_t    lc_reg;

    always_comb
    begin
        lim_s = $signed({1'b0, limit});
        if (q_cmd > lim_s)
            uq_next = lim_s;
        else if (q_cmd < -lim_s)
            uq_next = -lim_s;
        else
            uq_next = q_cmd;
        if (d_cmd > lim_s)
            ud_next = lim_s;
        else if (d_cmd < -lim_s)
            ud_next = -lim_s;
        else
            ud_next = d_cmd;
    end

    always_comb
    begin
        p_next[0] = 32'(ud_reg[4]) * 32'(cos_val);
        p_next[1] = 32'(uq_reg[4]) * 32'(sin_val);
        p_next[2] = 32'(uq_reg[4]) * 32'(cos_val);
        p_next[3] = 32'(ud_reg[4]) * 32'(sin_val);
        diff_c    = 33'(p_reg[0]) - 33'(p_reg[1]);
        sum_c     = 33'(p_reg[2]) + 33'(p_reg[3]);
        sa_prod_c = 44'($signed({1'b0, ipsv_pkg::SQRT3_Q16})) * 44'(al_reg);
    end

    // a, b and c are twice the textbook values
    always_comb
    begin
        a_c      = 28'(be8_reg) <<< 1;
        b_c      = sa_reg - 28'(be8_reg);
        c_c      = -(sa_reg + 28'(be8_reg));
        sec_next = ipsv_pkg::sector_lookup({c_c > 0, b_c > 0, a_c > 0});
        case (sec_next) inside
            ipsv_pkg::SEC_1, ipsv_pkg::SEC_4:
            begin
                la_next = a_c + b_c;
                lb_next = a_c - b_c;
                lc_next = -a_c - b_c;
            end
            ipsv_pkg::SEC_2, ipsv_pkg::SEC_5:
            begin
                la_next = b_c - c_c;
                lb_next = -b_c - c_c;
                lc_next = b_c + c_c;
            end
            ipsv_pkg::SEC_3, ipsv_pkg::SEC_6:
            begin
                la_next = -c_c - a_c;
                lb_next = c_c + a_c;
                lc_next = c_c - a_c;
            end
            default:
            begin
                la_next = '0;
                lb_next = '0;
                lc_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            uq_reg[0] <= uq_next;
            ud_reg[0] <= ud_next;
        end
        for (int k = 1; k < ipsv_pkg::TRIG_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                uq_reg[k] <= uq_reg[k-1];
                ud_reg[k] <= ud_reg[k-1];
            end
        end
        if (stage_en[5])
        begin
            for (int i = 0; i < 4; i++)
                p_reg[i] <= p_next[i];
        end
        if (stage_en[6])
        begin
            al_reg  <= diff_c[32:7];
            be7_reg <= sum_c[32:7];
        end
        if (stage_en[7])
        begin
            sa_reg  <= sa_prod_c[43:16];
            be8_reg <= be7_reg;
        end
        if (stage_en[8])
        begin
            sec_reg <= sec_next;
            la_reg  <= la_next;
            lb_reg  <= lb_next;
            lc_reg  <= lc_next;
        end
    end

    assign sector = sec_reg;
    assign l_a    = la_reg;
    assign l_b    = lb_reg;
    assign l_c    = lc_reg;

endmodule

FILE: rtl/ipsv_duty.sv
// one phase: scale by sqrt3, offset by half the supply, restoring divide by the supply
// depends on ipsv_pkg

module ipsv_duty (
    input  logic                               clk,
    input  logic [ipsv_pkg::DUTY_STAGES-1:0]   stage_en,
    input  logic [14:0]                        supply,
    input  ipsv_pkg::lvec_t                    l_val,
    output logic [11:0]                        duty
);

    localparam int NDIV = ipsv_pkg::DIV_BITS;

    logic signed [31:0] ph_reg;
    logic signed [31:0] ph_next;
    logic [30:0]        pl_reg;
    logic [30:0]        pl_next;
    logic signed [47:0] y_reg;
    logic signed [47:0] y_next;

    logic [40:0]        rem_reg [NDIV+1];
    logic [40:0]        rem_next [NDIV+1];
    logic [NDIV-1:0]    q_reg [NDIV+1];
    logic [NDIV-1:0]    q_next [NDIV+1];
    logic               zero_reg [NDIV+1];
    logic               zero_next;
    logic               sat_reg [NDIV+1];
    logic               sat_next;
    logic [41:0]        trial_c [NDIV+1];

    always_comb
    begin
        ph_next = 32'($signed({1'b0, ipsv_pkg::SQRT3_Q16})) * 32'($signed(l_val[27:14]));
        pl_next = 31'(ipsv_pkg::SQRT3_Q16) * 31'(l_val[13:0]);
        y_next  = (48'(ph_reg) <<< 14) + 48'($signed({1'b0, pl_reg}))
                + 48'($signed({1'b0, supply, 25'b0}));
        zero_next   = (y_reg <= 0);
        sat_next    = (y_reg >= 48'($signed({1'b0, supply, 26'b0})));
        rem_next[0] = y_reg[40:0];
        q_next[0]   = '0;
        trial_c[0]  = '0;
        for (int j = 1; j <= NDIV; j++)
        begin
            trial_c[j] = {1'b0, rem_reg[j-1]} - (42'(supply) << (15 + NDIV - j));
            if (!trial_c[j][41])
            begin
                rem_next[j] = trial_c[j][40:0];
                q_next[j]   = q_reg[j-1] | (NDIV'(1) << (NDIV - j));
            end
            else
            begin
                rem_next[j] = rem_reg[j-1];
                q_next[j]   = q_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
        end
        if (stage_en[1])
            y_reg <= y_next;
        if (stage_en[2])
        begin
            rem_reg[0]  <= rem_next[0];
            q_reg[0]    <= q_next[0];
            zero_reg[0] <= zero_next;
            sat_reg[0]  <= sat_next;
        end
        for (int j = 1; j <= NDIV; j++)
        begin
            if (stage_en[2+j])
            begin
                rem_reg[j]  <= rem_next[j];
                q_reg[j]    <= q_next[j];
                zero_reg[j] <= zero_reg[j-1];
                sat_reg[j]  <= sat_reg[j-1];
            end
        end
    end

    assign duty = zero_reg[NDIV] ? 12'd0
                : sat_reg[NDIV]  ? ipsv_pkg::PWM_FULL
                : 12'(q_reg[NDIV]);

endmodule

FILE: rtl/inverse_park_svpwm.sv
// top level: inverse park transform and space-vector pwm duty generation
// depends on ipsv_pkg, ipsv_trig, ipsv_park and ipsv_duty

// A pipeline of 23 register stages that takes one transaction per clock while
// the output side does not stall, and gives one result per transaction. The
// depth is set by the four dependent multiplies of the sine polynomial, the
// rotation and sqrt3 scaling, and the 11-stage restoring divide by the supply
// voltage in each phase. Empty stages close up under output backpressure, so
// the input keeps accepting while a result waits. supply_voltage should be
// written while the pipeline is empty; the clamp limit is registered from the
// stored supply, so it follows the write via supply_reg and then lim_reg.

module inverse_park_svpwm (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,     // q_voltage_cmd, d_voltage_cmd, electrical_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // duty_phase_a, duty_phase_b, duty_phase_c, sector_number
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data  // supply_voltage
);

    localparam int NS = ipsv_pkg::NUM_STAGES;
    localparam int NP = ipsv_pkg::PARK_STAGES;
    localparam int ND = ipsv_pkg::DUTY_STAGES;

    logic [14:0]   supply_reg;
    logic [14:0]   supply_next;
    logic [14:0]   lim_reg;
    logic [14:0]   lim_next;
    logic [29:0]   lim_prod;

    logic [NS:1]   valid_reg;
    logic [NS:1]   valid_next;
    logic [NS+1:1] en;

    logic signed [15:0] sin_val;
    logic signed [15:0] cos_val;
    ipsv_pkg::sector_t  park_sec;
    ipsv_pkg::lvec_t    l_a;
    ipsv_pkg::lvec_t    l_b;
    ipsv_pkg::lvec_t    l_c;
    ipsv_pkg::sector_t  sec_reg [ND];
    logic [11:0]        duty_a;
    logic [11:0]        duty_b;
    logic [11:0]        duty_c;
    logic               no_sector;

    always_comb
    begin
        supply_next = cfg_wr_en ? cfg_wr_data : supply_reg;
        lim_prod    = 30'(supply_reg) * 30'(ipsv_pkg::INV_SQRT3_Q15) + 30'd16384;
        lim_next    = lim_prod[29:15];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg <= ipsv_pkg::SUPPLY_RESET;
            lim_reg    <= ipsv_pkg::LIM_RESET;
        end
        else
        begin
            supply_reg <= supply_next;
            lim_reg    <= lim_next;
        end
    end

    // a stage loads when it is empty or the one after it moves
    always_comb
    begin
        en[NS+1] = m_tready;
        for (int k = NS; k >= 1; k--)
            en[k] = !valid_reg[k] || en[k+1];
        valid_next[1] = en[1] ? s_tvalid : valid_reg[1];
        for (int k = 2; k <= NS; k++)
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    ipsv_trig u_trig (
        .clk      (clk),
        .stage_en (en[ipsv_pkg::TRIG_STAGES:1]),
        .phase    ({s_tdata[47:32], 4'h0}),
        .sin_val  (sin_val),
        .cos_val  (cos_val)
    );

    ipsv_park u_park (
        .clk      (clk),
        .stage_en (en[NP:1]),
        .q_cmd    ($signed(s_tdata[15:0])),
        .d_cmd    ($signed(s_tdata[31:16])),
        .limit    (lim_reg),
        .sin_val  (sin_val),
        .cos_val  (cos_val),
        .sector   (park_sec),
        .l_a      (l_a),
        .l_b      (l_b),
        .l_c      (l_c)
    );

    ipsv_duty u_duty_a (
        .clk      (clk),
        .stage_en (en[NS:NP+1]),
        .supply   (supply_reg),
        .l_val    (l_a),
        .duty     (duty_a)
    );

    ipsv_duty u_duty_b (
        .clk      (clk),
        .stage_en (en[NS:NP+1]),
        .supply   (supply_reg),
        .l_val    (l_b),
        .duty     (duty_b)
    );

    ipsv_duty u_duty_c (
        .clk      (clk),
        .stage_en (en[NS:NP+1]),
        .supply   (supply_reg),
        .l_val    (l_c),
        .duty     (duty_c)
    );

    always_ff @(posedge clk)
    begin
        if (en[NP+1])
            sec_reg[0] <= park_sec;
        for (int k = 1; k < ND; k++)
        begin
            if (en[NP+1+k])
                sec_reg[k] <= sec_reg[k-1];
        end
    end

    assign no_sector = (sec_reg[ND-1] == ipsv_pkg::SEC_NONE);
    assign s_tready  = en[1];
    assign m_tvalid  = valid_reg[NS];
    assign m_tdata   = {1'b0, 3'(sec_reg[ND-1]),
                        no_sector ? 12'd0 : duty_c,
                        no_sector ? 12'd0 : duty_b,
                        no_sector ? 12'd0 : duty_a};

endmodule
